// ===== rtl/core/epa_pkg.sv =====
// ----------------------------------------------------------------------------
// epa_pkg
// Shared types and constants of the ensemble point accumulator: field widths,
// action and sample format codes, register addresses and the records that
// move between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package epa_pkg;

  // Defaults and fixed field widths
  localparam int unsigned POINTS_DEFAULT = 1024;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned PT_W           = 10;
  localparam int unsigned RAW_W          = 32;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned SUM_W          = 48;
  localparam int unsigned SQ_W           = 64;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned IN_DATA_W      = 48;
  localparam int unsigned IN_USER_W      = 4;
  localparam int unsigned OUT_DATA_W     = 192;
  localparam int unsigned APB_AW         = 4;

  // Saturation limits of the running sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Item actions; code 3 is unused and dropped
  typedef logic [1:0] action_t;
  localparam action_t ACT_ACCUM = 2'd0;
  localparam action_t ACT_COUNT = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  // Sample formats
  typedef enum logic [1:0] {
    ST_INT32 = 2'd0,
    ST_INT16 = 2'd1,
    ST_SBYTE = 2'd2,
    ST_UBYTE = 2'd3
  } sample_type_e;

  // Register byte addresses
  localparam logic [APB_AW-1:0] ADDR_SAMPLE_TYPE   = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_MISSING_CHECK = 4'h4;
  localparam logic [APB_AW-1:0] ADDR_MISSING_VALUE = 4'h8;

  // Configuration seen by the front end
  typedef struct packed {
    sample_type_e             sample_type;
    logic                     missing_check;
    logic signed [VAL_W-1:0]  missing_value;
  } cfg_t;

  // Classified item, as queued between front and back
  typedef struct packed {
    action_t                  action;
    logic [PT_W-1:0]          point;
    logic                     ensemble;
    logic                     first_member;
    logic                     in_range;
    logic                     missing;
    logic signed [VAL_W-1:0]  value;
    logic [VAL_W-1:0]         mag;
  } cmd_t;

  // One stored point record
  typedef struct packed {
    logic                     missing;
    logic signed [VAL_W-1:0]  max_v;
    logic signed [VAL_W-1:0]  min_v;
    logic [SQ_W-1:0]          sumsq;
    logic signed [SUM_W-1:0]  sum;
  } rec_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/epa_ram.sv =====
// ----------------------------------------------------------------------------
// epa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module epa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/epa_front.sv =====
// ----------------------------------------------------------------------------
// epa_front
// Input side: takes item transfers, reads the raw sample at the configured
// format, checks it against the missing value and the point range, and
// pushes the classified item into the command queue.
// ----------------------------------------------------------------------------
module epa_front import epa_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEFAULT
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,  // point, sample_raw, zero pad
  input  logic [IN_USER_W-1:0] s_axis_tuser_i,  // action, ensemble, first_member
  input  cfg_t                 cfg_i,
  input  q_status_t            q_status_i,
  input  logic                 clearing_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [PT_W-1:0]         point;
  logic [RAW_W-1:0]        raw;
  logic signed [VAL_W-1:0] value;

  assign point = s_axis_tdata_i[PT_W-1:0];
  assign raw   = s_axis_tdata_i[PT_W+RAW_W-1:PT_W];

  // Sample format decode
  always_comb begin
    unique case (cfg_i.sample_type)
      ST_INT32: value = raw;
      ST_INT16: value = {{16{raw[15]}}, raw[15:0]};
      ST_SBYTE: value = {{24{raw[7]}}, raw[7:0]};
      ST_UBYTE: value = {24'd0, raw[7:0]};
      default:  value = raw;
    endcase
  end

  // Classification
  always_comb begin
    cmd_o.action       = s_axis_tuser_i[1:0];
    cmd_o.ensemble     = s_axis_tuser_i[2];
    cmd_o.first_member = s_axis_tuser_i[3];
    cmd_o.point        = point;
    cmd_o.in_range     = (32'(point) < 32'(POINTS));
    cmd_o.missing      = cfg_i.missing_check && (value == cfg_i.missing_value);
    cmd_o.value        = value;
    cmd_o.mag          = value[VAL_W-1] ? (~value + 1'b1) : value;
  end

  // Handshake: held off while the store is being cleared
  assign s_axis_tready_o = !q_status_i.full && !clearing_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

endmodule

// ===== rtl/core/epa_queue.sv =====
// ----------------------------------------------------------------------------
// epa_queue
// Short command queue between the front end and the back end, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module epa_queue import epa_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entry_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  assign head_o         = entry_q[rd_q];
  assign status_o.full  = (cnt_q == CW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/core/epa_back.sv =====
// ----------------------------------------------------------------------------
// epa_back
// Execution side: clears the record store after reset, then takes queued
// items one at a time and does the read-modify-write of the point record
// (saturating sums, min/max, sticky missing mark), counts members and
// returns point records through an output register.
// ----------------------------------------------------------------------------
module epa_back import epa_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  head_i,
  input  q_status_t             q_status_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o, // sum, sumsq, min, max, count
  output logic [0:0]            m_axis_tuser_o  // missing
);

  localparam int unsigned SLOTS = 2 * POINTS;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned RW    = $bits(rec_t);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUTPUT = 5'b10000
  } state_e;

  function automatic logic [AW-1:0] slot_of(input cmd_t c);
    return c.ensemble ? AW'(POINTS) + AW'(c.point) : AW'(c.point);
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  cmd_t                   cmd_q, cmd_d;
  logic [AW-1:0]          idx_q, idx_d;
  rec_t                   rec_q, rec_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic [CNT_W-1:0]       cnt_q [2];
  logic                   cnt_inc;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic                   out_miss_q, out_miss_d;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;
  logic [RW-1:0]          ram_rdata;

  logic signed [SUM_W:0]  sum_ext;
  logic [SQ_W:0]          sq_ext;
  rec_t                   rec_new;

  // Record store
  epa_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_epa_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_of(head_i)),
    .rdata_o (ram_rdata)
  );

  // Record update: saturating sums, min/max, sticky missing mark
  always_comb begin
    sum_ext = {rec_q.sum[SUM_W-1], rec_q.sum} + {{(SUM_W+1-VAL_W){cmd_q.value[VAL_W-1]}},
                                                 cmd_q.value};
    sq_ext  = {1'b0, rec_q.sumsq} + {1'b0, sq_q};
    rec_new = rec_q;
    if (rec_q.missing || cmd_q.missing) begin
      rec_new.missing = 1'b1;
    end else begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        rec_new.sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        rec_new.sum = sum_ext[SUM_W-1:0];
      end
      rec_new.sumsq = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
      if (cmd_q.first_member) begin
        rec_new.min_v = cmd_q.value;
        rec_new.max_v = cmd_q.value;
      end else begin
        if (cmd_q.value > rec_q.max_v) rec_new.max_v = cmd_q.value;
        if (cmd_q.value < rec_q.min_v) rec_new.min_v = cmd_q.value;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    rec_d       = rec_q;
    sq_d        = sq_q;
    cnt_inc     = 1'b0;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = rec_new;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_miss_d  = out_miss_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          idx_d = slot_of(head_i);
          if (head_i.action == ACT_READ ||
              (head_i.action == ACT_ACCUM && head_i.in_range)) begin
            ram_re  = 1'b1;
            state_d = ST_LOAD;
          end else if (head_i.action == ACT_COUNT) begin
            cnt_inc = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        rec_d   = cmd_q.in_range ? rec_t'(ram_rdata) : '0;
        sq_d    = SQ_W'(cmd_q.mag) * SQ_W'(cmd_q.mag);
        state_d = (cmd_q.action == ACT_READ) ? ST_OUTPUT : ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_OUTPUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {cnt_q[cmd_q.ensemble], rec_q.max_v, rec_q.min_v,
                         rec_q.sumsq, rec_q.sum};
          out_miss_d  = rec_q.missing;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cnt_inc && cnt_q[cmd_d.ensemble] != {CNT_W{1'b1}}) begin
        cnt_q[cmd_d.ensemble] <= cnt_q[cmd_d.ensemble] + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    rec_q      <= rec_d;
    sq_q       <= sq_d;
    out_data_q <= out_data_d;
    out_miss_q <= out_miss_d;
  end

  assign clearing_o      = (state_q == ST_CLEAR);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_miss_q;

endmodule

// ===== rtl/core/ensemble_point_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// ensemble_point_accumulator_core
// Per-point, per-ensemble running sum, sum of squares, min, max and missing
// mark, with member counters, an APB register port and stream interfaces.
// ----------------------------------------------------------------------------
// After reset the block clears the 2*POINTS records of the record store (one
// record a cycle) and holds s_axis_tready_o low; register writes are taken
// during it. Items then enter a four-deep command queue and are executed one
// at a time by the back end: an accumulate item goes through the idle, load and
// update states (record read, square, saturating update and write back), a read
// item through idle, load and output plus any wait on the output register, and
// a count item, an item with an unused action and an accumulate to a point
// beyond POINTS end in idle. The steps follow from the read-modify-write of the
// single record memory and the registered 32x32 square. Results leave through
// an output register, so the queue keeps filling while a result awaits transfer.
// ----------------------------------------------------------------------------
module ensemble_point_accumulator_core import epa_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [9:0] point, [41:10] sample_raw
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,  // [1:0] action, [2] ensemble,
                                                 // [3] first_member
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [47:0] sum_out, [111:48] sumsq_out,
                                                 // [143:112] min_out, [175:144] max_out,
                                                 // [191:176] count_out
  output logic [0:0]            m_axis_tuser_o,  // [0] missing_out
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t      cfg_q;
  logic      cfg_we;
  logic      push, pop, clearing;
  cmd_t      cmd, head;
  q_status_t q_status;

  // Register writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_type   <= ST_INT32;
      cfg_q.missing_check <= 1'b0;
      cfg_q.missing_value <= '0;
    end else if (cfg_we) begin
      if (paddr == ADDR_SAMPLE_TYPE)   cfg_q.sample_type   <= sample_type_e'(pwdata[1:0]);
      if (paddr == ADDR_MISSING_CHECK) cfg_q.missing_check <= pwdata[0];
      if (paddr == ADDR_MISSING_VALUE) cfg_q.missing_value <= pwdata;
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr)
      ADDR_SAMPLE_TYPE:   prdata = {30'd0, cfg_q.sample_type};
      ADDR_MISSING_CHECK: prdata = {31'd0, cfg_q.missing_check};
      ADDR_MISSING_VALUE: prdata = cfg_q.missing_value;
      default:            prdata = '0;
    endcase
  end

  epa_front #(
    .POINTS (POINTS)
  ) u_epa_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_i           (cfg_q),
    .q_status_i      (q_status),
    .clearing_i      (clearing),
    .push_o          (push),
    .cmd_o           (cmd)
  );

  epa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_epa_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  epa_back #(
    .POINTS (POINTS)
  ) u_epa_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== rtl/core/epa_checker.sv =====
// ----------------------------------------------------------------------------
// epa_port_checks
// Port-level checks of the ensemble point accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module epa_port_checks import epa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // sum, sumsq, min, max, count
  input logic [0:0]            m_axis_tuser_o,  // missing
  input logic                  psel,
  input logic                  pready
);

  logic signed [VAL_W-1:0] min_v, max_v;
  logic [SQ_W-1:0]         sumsq;
  logic [SUM_W-1:0]        sum;

  assign sum   = m_axis_tdata_o[47:0];
  assign sumsq = m_axis_tdata_o[111:48];
  assign min_v = m_axis_tdata_o[143:112];
  assign max_v = m_axis_tdata_o[175:144];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // First member loads both bounds, so min never passes max
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> min_v <= max_v)
    else $error("record min above max");

  // Zero sum of squares means only zero samples were summed
  a_sq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && sumsq == '0 |-> sum == '0)
    else $error("nonzero sum with zero sum of squares");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low");

endmodule

bind ensemble_point_accumulator_core epa_port_checks u_epa_port_checks (.*);

// ===== sim/epa_checker.sv =====
// ----------------------------------------------------------------------------
// epa_checker
// Watches the item, result and register channels of the ensemble point
// accumulator. It keeps its own copy of the per-point records, the member
// counts and the configuration, predicts the record returned by each read
// item and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module epa_checker import epa_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [9:0] point, [41:10] sample_raw
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,  // [1:0] action, [2] ensemble,
                                                 // [3] first_member
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,  // [47:0] sum, [111:48] sumsq,
                                                 // [143:112] min, [175:144] max,
                                                 // [191:176] count
  input  logic [0:0]            m_axis_tuser_i,  // [0] missing
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = 2 * POINTS;
  localparam int unsigned SHOW_MAX  = 10;
  localparam longint      SUM_HI    = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint      SUM_LO    = -SUM_HI - 1;

  // One point record as it leaves the block
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic signed [VAL_W-1:0] min_v;
    logic signed [VAL_W-1:0] max_v;
    logic                    missing;
    logic [CNT_W-1:0]        count;
  } point_record_t;

  // Shadow record store, member counts and configuration
  logic signed [SUM_W-1:0] sum_mem     [SLOTS];
  logic [SQ_W-1:0]         sumsq_mem   [SLOTS];
  logic signed [VAL_W-1:0] min_mem     [SLOTS];
  logic signed [VAL_W-1:0] max_mem     [SLOTS];
  logic                    missing_mem [SLOTS];
  logic [CNT_W-1:0]        members     [2];
  sample_type_e            cur_type;
  logic                    cur_check;
  logic signed [VAL_W-1:0] cur_missing;

  point_record_t expected_records [$];
  int            mismatches = 0;

  // Extend the raw sample bits per the configured format
  function automatic longint widen_sample(logic [RAW_W-1:0] raw);
    case (cur_type)
      ST_INT32: return longint'($signed(raw));
      ST_INT16: return longint'($signed(raw[15:0]));
      ST_SBYTE: return longint'($signed(raw[7:0]));
      default:  return longint'(raw[7:0]);
    endcase
  endfunction

  // Apply one accepted item to the shadow state; reads queue a record
  function automatic void fold_item(action_t act, logic [PT_W-1:0] pt, logic ens,
                                    logic first, logic [RAW_W-1:0] raw);
    int unsigned   slot;
    logic          in_range;
    longint        z;
    longint        s;
    logic [SQ_W-1:0] mag;
    logic [SQ_W:0] sq_sum;
    point_record_t rec;
    in_range = (pt < POINTS);
    slot     = ens * POINTS + pt;
    case (act)
      ACT_ACCUM: begin
        if (in_range) begin
          z = widen_sample(raw);
          if (cur_check && z == longint'(cur_missing)) missing_mem[slot] = 1'b1;
          if (!missing_mem[slot]) begin
            s = longint'(sum_mem[slot]) + z;
            if (s > SUM_HI) s = SUM_HI;
            else if (s < SUM_LO) s = SUM_LO;
            sum_mem[slot] = s[SUM_W-1:0];
            mag = (z < 0) ? SQ_W'(-z) : SQ_W'(z);
            sq_sum = {1'b0, sumsq_mem[slot]} + (mag * mag);
            sumsq_mem[slot] = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
            if (first) begin
              min_mem[slot] = z[VAL_W-1:0];
              max_mem[slot] = z[VAL_W-1:0];
            end else begin
              if (z > longint'(max_mem[slot])) max_mem[slot] = z[VAL_W-1:0];
              if (z < longint'(min_mem[slot])) min_mem[slot] = z[VAL_W-1:0];
            end
          end
        end
      end
      ACT_COUNT: begin
        if (members[ens] != '1) members[ens] = members[ens] + 1'b1;
      end
      ACT_READ: begin
        rec = '0;
        if (in_range) begin
          rec.sum     = sum_mem[slot];
          rec.sumsq   = sumsq_mem[slot];
          rec.min_v   = min_mem[slot];
          rec.max_v   = max_mem[slot];
          rec.missing = missing_mem[slot];
        end
        rec.count = members[ens];
        expected_records.push_back(rec);
      end
      default: ;  // unused action: dropped by the block
    endcase
  endfunction

  // Compare one result transfer with the oldest pending record
  function automatic void check_result(logic [OUT_DATA_W-1:0] data, logic missing);
    point_record_t got;
    point_record_t want;
    got.sum     = data[47:0];
    got.sumsq   = data[111:48];
    got.min_v   = data[143:112];
    got.max_v   = data[175:144];
    got.count   = data[191:176];
    got.missing = missing;
    if (expected_records.size() == 0) begin
      if (mismatches < SHOW_MAX)
        $display("%t: result with no read pending: sum=%0d sumsq=%0h min=%0d max=%0d",
                 $realtime, got.sum, got.sumsq, got.min_v, got.max_v);
      mismatches++;
    end else begin
      want = expected_records.pop_front();
      if (got != want) begin
        if (mismatches < SHOW_MAX) begin
          $display("%t: record mismatch (expected / actual)", $realtime);
          if (got.sum != want.sum)
            $display("  sum     %0d / %0d", want.sum, got.sum);
          if (got.sumsq != want.sumsq)
            $display("  sumsq   %0h / %0h", want.sumsq, got.sumsq);
          if (got.min_v != want.min_v)
            $display("  min     %0d / %0d", want.min_v, got.min_v);
          if (got.max_v != want.max_v)
            $display("  max     %0d / %0d", want.max_v, got.max_v);
          if (got.missing != want.missing)
            $display("  missing %0b / %0b", want.missing, got.missing);
          if (got.count != want.count)
            $display("  count   %0d / %0d", want.count, got.count);
        end
        mismatches++;
      end
    end
  endfunction

  // Monitor: results first, so a result never meets a prediction of its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        sum_mem[k]     = '0;
        sumsq_mem[k]   = '0;
        min_mem[k]     = '0;
        max_mem[k]     = '0;
        missing_mem[k] = 1'b0;
      end
      members[0]  = '0;
      members[1]  = '0;
      cur_type    = ST_INT32;
      cur_check   = 1'b0;
      cur_missing = '0;
      expected_records.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i, m_axis_tuser_i[0]);
      if (s_axis_tvalid_i && s_axis_tready_i)
        fold_item(s_axis_tuser_i[1:0], s_axis_tdata_i[9:0], s_axis_tuser_i[2],
                  s_axis_tuser_i[3], s_axis_tdata_i[41:10]);
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_SAMPLE_TYPE:   cur_type    = sample_type_e'(pwdata[1:0]);
          ADDR_MISSING_CHECK: cur_check   = pwdata[0];
          ADDR_MISSING_VALUE: cur_missing = pwdata;
          default: ;
        endcase
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_records.size();
  end

endmodule

// ===== sim/tb_ensemble_point_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_ensemble_point_accumulator_core
// Drives the accumulator with a directed opening (field extremes, every
// action, saturation of the square sum, missing marks), then random phases
// over all sample formats and idle patterns, and a short closing run of
// extreme same-sign samples at two untouched points. A checker module
// predicts and compares the read records; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ensemble_point_accumulator_core import epa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD      = 20ns;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned HOT_POINTS      = 12;
  localparam int unsigned SAT_ITEMS       = 8;
  localparam logic [PT_W-1:0] SAT_HI_POINT = 10'd1000;
  localparam logic [PT_W-1:0] SAT_LO_POINT = 10'd1001;
  localparam action_t     ACT_UNUSED      = 2'd3;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid   = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata    = '0;  // [9:0] point, [41:10] sample_raw
  logic [IN_USER_W-1:0]  s_axis_tuser    = '0;  // [1:0] action, [2] ensemble,
                                                // [3] first_member
  logic                  m_axis_tvalid;
  logic                  m_axis_tready   = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // [47:0] sum, [111:48] sumsq,
                                                // [143:112] min, [175:144] max,
                                                // [191:176] count
  logic [0:0]            m_axis_tuser;          // [0] missing
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [APB_AW-1:0]     paddr           = '0;
  logic [31:0]           pwdata          = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int          fail_count;
  int          pending;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned cycles        = 0;

  ensemble_point_accumulator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  epa_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[ensemble_point_accumulator_core] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // One item transfer; called and returning at a falling edge
  task automatic send_item(action_t act, logic [PT_W-1:0] pt, logic ens, logic first,
                           logic [RAW_W-1:0] raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, raw, pt};
    s_axis_tuser  <= {first, ens, act};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Register write: setup then access phase
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every read record, then let queued work drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Any point except the two kept clean for the closing run
  function automatic logic [PT_W-1:0] any_point();
    logic [PT_W-1:0] pt;
    pt = PT_W'($urandom_range(POINTS_DEFAULT - 1));
    if (pt == SAT_HI_POINT || pt == SAT_LO_POINT) pt = pt - 10'd2;
    return pt;
  endfunction

  // Raw sample: missing pattern, format extremes, small values or noise
  function automatic logic [31:0] pick_raw(sample_type_e st, logic [31:0] mv);
    logic [31:0] raw;
    int unsigned r;
    raw = $urandom;
    r   = $urandom_range(99);
    if (r < 6) begin
      case (st)
        ST_INT32: raw = mv;
        ST_INT16: raw[15:0] = mv[15:0];
        default:  raw[7:0] = mv[7:0];
      endcase
    end else if (r < 20) begin
      case ($urandom_range(5))
        0:       raw = 32'h0000_0000;
        1:       raw = 32'h7FFF_FFFF;
        2:       raw = 32'h8000_0000;
        3:       raw = 32'hFFFF_FFFF;
        4:       raw[15:0] = 16'h8000;
        default: raw[7:0] = 8'h80;
      endcase
    end else if (r < 45) begin
      raw = {{24{raw[31]}}, raw[7:0]};
    end
    return raw;
  endfunction

  // Stimulus
  initial begin
    sample_type_e    st;
    logic            chk;
    logic [31:0]     mv;
    logic [31:0]     rnd;
    action_t         act;
    int unsigned     r;
    logic [PT_W-1:0] pt;
    logic [PT_W-1:0] hot_points [HOT_POINTS];

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration written back while the store clears
    write_reg(ADDR_SAMPLE_TYPE, {30'b0, ST_INT32});
    write_reg(ADDR_MISSING_CHECK, 32'd0);
    write_reg(ADDR_MISSING_VALUE, 32'd0);

    // Directed: field extremes, back-to-back same point, every action
    send_item(ACT_ACCUM, 10'd0, 1'b0, 1'b1, 32'h7FFF_FFFF);
    send_item(ACT_ACCUM, 10'd0, 1'b0, 1'b0, 32'h8000_0000);
    send_item(ACT_READ, 10'd0, 1'b0, 1'b0, 32'h0);
    // four squares of the most negative sample overflow the square sum
    for (int k = 0; k < 4; k++) send_item(ACT_ACCUM, 10'd1023, 1'b1, k == 0, 32'h8000_0000);
    send_item(ACT_READ, 10'd1023, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_COUNT, 10'd0, 1'b0, 1'b0, 32'h0);
    send_item(ACT_COUNT, 10'd1023, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_UNUSED, 10'd5, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_READ, 10'd5, 1'b0, 1'b0, 32'h0);
    send_item(ACT_READ, 10'd1023, 1'b0, 1'b0, 32'h0);
    send_item(ACT_READ, 10'd0, 1'b1, 1'b0, 32'h0);

    // Directed: missing mark freezes the point
    settle();
    write_reg(ADDR_SAMPLE_TYPE, {30'b0, ST_INT16});
    write_reg(ADDR_MISSING_CHECK, 32'd1);
    write_reg(ADDR_MISSING_VALUE, 32'hFFFF_FFFF);
    send_item(ACT_ACCUM, 10'd7, 1'b0, 1'b1, 32'h0001_8000);
    send_item(ACT_ACCUM, 10'd7, 1'b0, 1'b0, 32'h1234_7FFF);
    send_item(ACT_READ, 10'd7, 1'b0, 1'b0, 32'h0);
    send_item(ACT_ACCUM, 10'd7, 1'b0, 1'b0, 32'hABCD_FFFF);
    send_item(ACT_ACCUM, 10'd7, 1'b0, 1'b1, 32'h0000_0005);
    send_item(ACT_READ, 10'd7, 1'b0, 1'b0, 32'h0);

    // Random phases over formats, missing settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      settle();
      rnd = $urandom;
      case (p)
        0:       begin st = ST_INT32; chk = 1'b1; mv = 32'h8000_0000; end
        1:       begin st = ST_INT16; chk = 1'b1; mv = 32'hFFFF_FFFF; end
        2:       begin st = ST_SBYTE; chk = 1'b1; mv = 32'h0000_007F; end
        3:       begin st = ST_UBYTE; chk = 1'b1; mv = 32'h0000_00FF; end
        4:       begin st = ST_INT32; chk = 1'b0; mv = 32'h7FFF_FFFF; end
        5:       begin st = ST_SBYTE; chk = 1'b1; mv = 32'hFFFF_FF80; end
        6:       begin st = ST_UBYTE; chk = 1'b0; mv = 32'h0000_0000; end
        default: begin st = ST_INT16; chk = 1'b1; mv = {{16{rnd[15]}}, rnd[15:0]}; end
      endcase
      write_reg(ADDR_SAMPLE_TYPE, {30'b0, st});
      write_reg(ADDR_MISSING_CHECK, {31'b0, chk});
      write_reg(ADDR_MISSING_VALUE, mv);

      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase

      // a small working set so points see many samples in a row
      foreach (hot_points[h]) hot_points[h] = any_point();
      if (p % 2 == 0) begin
        hot_points[0] = 10'd0;
        hot_points[1] = 10'd1023;
      end

      // result side holds off while items keep coming: queue fills, input stalls
      if (p == 0) hold_requests++;

      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 55)      act = ACT_ACCUM;
        else if (r < 65) act = ACT_COUNT;
        else if (r < 95) act = ACT_READ;
        else             act = ACT_UNUSED;
        pt = ($urandom_range(99) < 85) ? hot_points[$urandom_range(HOT_POINTS - 1)]
                                       : any_point();
        send_item(act, pt, 1'($urandom_range(1)), ($urandom_range(99) < 15),
                  pick_raw(st, mv));
      end
    end

    // Closing run: largest and smallest samples at two clean points, member counts
    settle();
    write_reg(ADDR_SAMPLE_TYPE, {30'b0, ST_INT32});
    write_reg(ADDR_MISSING_CHECK, 32'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int k = 0; k < SAT_ITEMS; k++) begin
      send_item(ACT_ACCUM, SAT_HI_POINT, 1'b0, k == 0, 32'h7FFF_FFFF);
      send_item(ACT_ACCUM, SAT_LO_POINT, 1'b1, k == 0, 32'h8000_0000);
      send_item(ACT_COUNT, 10'd0, 1'b1, 1'b0, 32'h0);
      if (k % 8192 == 0 || k >= SAT_ITEMS - 4) begin
        send_item(ACT_READ, SAT_HI_POINT, 1'b0, 1'b0, 32'h0);
        send_item(ACT_READ, SAT_LO_POINT, 1'b1, 1'b0, 32'h0);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[ensemble_point_accumulator_core] OK");
    end else begin
      $display("[ensemble_point_accumulator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/epa_pkg.sv
rtl/core/epa_ram.sv
rtl/core/epa_front.sv
rtl/core/epa_queue.sv
rtl/core/epa_back.sv
rtl/core/ensemble_point_accumulator_core.sv
rtl/core/epa_checker.sv
sim/epa_checker.sv
sim/tb_ensemble_point_accumulator_core.sv
